@@ rtl/tmrf_pkg.sv @@
package tmrf_pkg;

  // Sizes
  localparam int MAX_WINDOW  = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int LA_DEPTH    = MAX_WINDOW + 1;
  localparam int WIN_W       = 5;
  localparam int FILL_W      = 6;
  localparam int LA_IDX_W    = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF    = 2'd0,
    CFG_DIST_MODE = 2'd1,
    CFG_WINDOW    = 2'd2
  } cfg_idx_t;

  // Input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          is_last;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic reliable;
    logic last_out;
  } out_item_t;

  // Classified position handed from the input stage to the core
  typedef struct packed {
    logic mark;
    logic last;
  } mark_item_t;

  // Core to output stage
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

@@ rtl/tmrf_in_stage.sv @@
module tmrf_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  tmrf_pkg::in_item_t                  in_data,
  output logic                                in_stall,
  input  logic signed [tmrf_pkg::CFG_DATA_W-1:0] cutoff,
  input  logic                                distance_mode,
  output logic                                item_valid,
  output tmrf_pkg::mark_item_t                item,
  input  logic                                absorb
);

  logic                 valid_r;
  tmrf_pkg::mark_item_t item_r;
  logic                 mark;
  logic signed [tmrf_pkg::SAMPLE_BITS-1:0] v;

  // Classify the incoming sample
  always_comb begin
    v = in_data.sample_value;
    if (distance_mode) begin
      mark = (v > 0) && (v <= cutoff);
    end else begin
      mark = (v >= cutoff);
    end
  end

  // Hold the item until the core takes it
  assign in_stall = valid_r && !absorb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.mark <= mark;
      item_r.last <= in_data.is_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/tmrf_core.sv @@
module tmrf_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tmrf_pkg::WIN_W-1:0]       window,
  input  logic                             item_valid,
  input  tmrf_pkg::mark_item_t             item,
  output logic                             absorb,
  input  logic                             out_ready,
  output tmrf_pkg::emit_t                  emit_o
);

  logic [tmrf_pkg::LA_DEPTH-1:0] marks_r, marks_nxt;
  logic [tmrf_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [tmrf_pkg::WIN_W-1:0]    left_run_r, left_run_nxt;
  logic                          drain_r, drain_nxt;
  logic                          flush_r, flush_nxt;

  logic [tmrf_pkg::FILL_W-1:0]   w6;
  logic [tmrf_pkg::FILL_W-1:0]   lim;
  logic                          need_emit;
  logic                          emit;
  logic                          is_final;
  logic [tmrf_pkg::LA_DEPTH-2:0] run_bits;
  logic [tmrf_pkg::WIN_W-1:0]    ahead;
  logic [tmrf_pkg::WIN_W-1:0]    behind;
  logic [tmrf_pkg::WIN_W+1:0]    total;
  logic                          keep;
  logic [tmrf_pkg::FILL_W-1:0]   wr_idx;

  // Pending-emission control
  always_comb begin
    w6        = {1'b0, window};
    need_emit = drain_r && (flush_r ? (fill_r != '0) : (fill_r > w6));
    emit      = need_emit && out_ready;
    is_final  = flush_r && (fill_r == 6'd1);
    // A new mark lands beyond the span the oldest position looks at, so it
    // may enter together with the last emission of the previous item.
    absorb    = item_valid && !flush_r &&
                (!need_emit || (emit && (fill_r == w6 + 6'd1)));
  end

  // Run of raw marks ahead of the oldest position, bounded by lim
  always_comb begin
    if (fill_r == '0) begin
      lim = '0;
    end else if ((fill_r - 6'd1) > w6) begin
      lim = w6;
    end else begin
      lim = fill_r - 6'd1;
    end
    for (int i = 1; i < tmrf_pkg::LA_DEPTH; i++) begin
      run_bits[i-1] = marks_r[i] && (i <= int'(lim));
    end
    // trailing ones count: index of the first unmarked slot
    ahead = tmrf_pkg::WIN_W'(tmrf_pkg::LA_DEPTH - 1);
    for (int i = tmrf_pkg::LA_DEPTH - 2; i >= 0; i--) begin
      if (!run_bits[i]) begin
        ahead = tmrf_pkg::WIN_W'(i);
      end
    end
    behind = (left_run_r < window) ? left_run_r : window;
    total  = {2'b00, ahead} + {2'b00, behind} + 7'd1;
    keep   = marks_r[0] && (total >= {2'b00, window});
  end

  // Next state
  always_comb begin
    marks_nxt    = emit ? (marks_r >> 1) : marks_r;
    wr_idx       = fill_r - {5'd0, emit};
    if (absorb) begin
      marks_nxt[wr_idx[tmrf_pkg::LA_IDX_W-1:0]] = item.mark;
    end
    fill_nxt     = fill_r + {5'd0, absorb} - {5'd0, emit};
    left_run_nxt = left_run_r;
    if (emit) begin
      if (is_final || !keep) begin
        left_run_nxt = '0;
      end else if (left_run_r != tmrf_pkg::WIN_W'(tmrf_pkg::MAX_WINDOW)) begin
        left_run_nxt = left_run_r + 5'd1;
      end
    end
    flush_nxt = flush_r;
    if (absorb && item.last) begin
      flush_nxt = 1'b1;
    end else if (emit && is_final) begin
      flush_nxt = 1'b0;
    end
    drain_nxt = absorb || need_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r    <= '0;
      fill_r     <= '0;
      left_run_r <= '0;
      drain_r    <= 1'b0;
      flush_r    <= 1'b0;
    end else begin
      marks_r    <= marks_nxt;
      fill_r     <= fill_nxt;
      left_run_r <= left_run_nxt;
      drain_r    <= drain_nxt;
      flush_r    <= flush_nxt;
    end
  end

  assign emit_o.valid         = emit;
  assign emit_o.item.reliable = keep;
  assign emit_o.item.last_out = is_final;

endmodule

@@ rtl/tmrf_out_stage.sv @@
module tmrf_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  tmrf_pkg::emit_t     emit_i,
  output logic                out_ready,
  output logic                out_valid,
  output tmrf_pkg::out_item_t out_data,
  input  logic                out_stall
);

  logic                valid_r;
  tmrf_pkg::out_item_t data_r;

  // Register can take a new result when empty or draining this cycle
  assign out_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= emit_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && emit_i.valid) begin
      data_r <= emit_i.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/threshold_min_run_filter.sv @@
// A position's result passes the input register, the lookahead and the output
// register after the input transaction that releases it.
// Throughput: one position per cycle in steady state while out_stall is low; a
// final position or a lowered window releases several results, one per cycle, and
// input stalls meanwhile. Rate is set by the lookahead shift and run count.
// Reset (synchronous, rst_n low): cutoff 0, score mode, window 3, lookahead empty.
module threshold_min_run_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  tmrf_pkg::in_item_t                    in_data,
  output logic                                  in_stall,
  output logic                                  out_valid,
  output tmrf_pkg::out_item_t                   out_data,
  input  logic                                  out_stall,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmrf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tmrf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  logic signed [tmrf_pkg::CFG_DATA_W-1:0] cutoff_r;
  logic                                   dist_mode_r;
  logic [tmrf_pkg::WIN_W-1:0]             window_r;

  logic                 item_valid;
  tmrf_pkg::mark_item_t item;
  logic                 absorb;
  logic                 out_ready;
  tmrf_pkg::emit_t      emit;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= '0;
      dist_mode_r <= 1'b0;
      window_r    <= 5'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmrf_pkg::CFG_CUTOFF:    cutoff_r    <= cfg_wdata;
        tmrf_pkg::CFG_DIST_MODE: dist_mode_r <= cfg_wdata[0];
        tmrf_pkg::CFG_WINDOW:    window_r    <= cfg_wdata[tmrf_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  tmrf_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .cutoff        (cutoff_r),
    .distance_mode (dist_mode_r),
    .item_valid    (item_valid),
    .item          (item),
    .absorb        (absorb)
  );

  tmrf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .window     (window_r),
    .item_valid (item_valid),
    .item       (item),
    .absorb     (absorb),
    .out_ready  (out_ready),
    .emit_o     (emit)
  );

  tmrf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_i    (emit),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tmrf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_GAP   = 6;
  localparam int TAIL_CYCLES  = 20;
  localparam int LONG_HOLD    = 300;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 25;
  localparam int REPORT_LINES = 100;
  // index with no register behind it; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Scoreboard: tracks the run filter state and the results still owed
  class min_run_scoreboard;
    int        cutoff;
    bit        dist_mode;
    bit [4:0]  window;
    bit        marks [LA_DEPTH];
    int        fill;
    int        left_run;
    out_item_t due_results [$];
    int        mismatches;
    int        results_seen;

    function new();
      cutoff = 0;
      dist_mode = 1'b0;
      window = 5'd3;
      fill = 0;
      left_run = 0;
      mismatches = 0;
      results_seen = 0;
      foreach (marks[i]) marks[i] = 1'b0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("MISMATCH %0t: %s", $time, msg);
    endtask

    function int pending();
      return due_results.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_CUTOFF:    cutoff = int'($signed(d));
        CFG_DIST_MODE: dist_mode = d[0];
        CFG_WINDOW:    window = d[4:0];
        default: ;
      endcase
    endfunction

    // Decide the oldest waiting position and queue its result
    function void release_oldest(bit fin);
      int        ahead;
      int        behind;
      int        lim;
      bit        run_open;
      bit        keep;
      out_item_t r;
      lim = (fill > 0) ? fill - 1 : 0;
      if (lim > int'(window)) lim = int'(window);
      ahead = 0;
      run_open = 1'b1;
      for (int i = 1; i <= lim; i++) begin
        if (!marks[i]) run_open = 1'b0;
        if (run_open) ahead++;
      end
      behind = (left_run < int'(window)) ? left_run : int'(window);
      keep = marks[0] && (ahead + behind >= int'(window) - 1);
      if (keep) left_run = (left_run < MAX_WINDOW) ? left_run + 1 : MAX_WINDOW;
      else left_run = 0;
      if (fill > 0) begin
        for (int i = 0; i < LA_DEPTH - 1; i++) marks[i] = marks[i + 1];
        marks[LA_DEPTH - 1] = 1'b0;
        fill--;
      end
      r.reliable = keep;
      r.last_out = fin;
      due_results.push_back(r);
    endfunction

    // Classify one accepted position and release what it makes ready
    function void note_position(in_item_t it);
      int v;
      bit mark;
      v = int'($signed(it.sample_value));
      if (dist_mode) mark = (v > 0) && (v <= cutoff);
      else mark = (v >= cutoff);
      if (fill >= LA_DEPTH) release_oldest(1'b0);
      marks[fill] = mark;
      fill++;
      if (it.is_last) begin
        while (fill > 0) release_oldest(fill == 1);
        foreach (marks[i]) marks[i] = 1'b0;
        fill = 0;
        left_run = 0;
      end else begin
        while (fill > int'(window)) release_oldest(1'b0);
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with none outstanding", results_seen));
      end else begin
        want = due_results.pop_front();
        if (got.reliable !== want.reliable)
          report($sformatf("result %0d reliable %b, expected %b",
                           results_seen, got.reliable, want.reliable));
        if (got.last_out !== want.last_out)
          report($sformatf("result %0d last_out %b, expected %b",
                           results_seen, got.last_out, want.last_out));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  in_item_t              in_data;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  out_stall;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  min_run_scoreboard sb;
  int  cycle_count;
  int  hold_left;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  seq_left;
  bit  want_mark;

  threshold_min_run_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycle_count = 0;
    hold_left = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    seq_left = 0;
    want_mark = 1'b0;
    sb = new();
  end

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_position(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Result receiver: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < 21);
    end
  end

  task automatic send(in_item_t it);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_val(int v, bit last);
    in_item_t it;
    it.sample_value = 16'(v);
    it.is_last = last;
    send(it);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Value that lands on the wanted side of the current cutoff
  function automatic logic signed [15:0] pick_sample(bit want);
    int lo;
    int hi;
    if (sb.dist_mode) begin
      if (want) begin
        lo = 1;
        hi = sb.cutoff;
      end else if (sb.cutoff < 32767 && $urandom_range(0, 1) == 1) begin
        lo = sb.cutoff + 1;
        hi = 32767;
      end else begin
        lo = -32768;
        hi = 0;
      end
    end else begin
      lo = want ? sb.cutoff : -32768;
      hi = want ? 32767 : sb.cutoff - 1;
    end
    if (hi < lo) begin
      lo = -32768;
      hi = 32767;
    end
    case ($urandom_range(0, 7))
      0:       return 16'(lo);
      1:       return 16'(hi);
      default: return 16'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // Sequences of random length built from runs of marks, with some noise
  task automatic send_stream(int count);
    in_item_t it;
    repeat (count) begin
      if (seq_left == 0)
        seq_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 70);
      if ($urandom_range(0, 3) == 0) want_mark = !want_mark;
      if ($urandom_range(0, 99) < 12) it.sample_value = 16'($urandom);
      else it.sample_value = pick_sample(want_mark);
      it.is_last = (seq_left == 1);
      seq_left--;
      send(it);
    end
  endtask

  task automatic random_config(int phase);
    logic [4:0]  w;
    logic [15:0] c;
    case ($urandom_range(0, 4))
      0:       w = 5'($urandom_range(0, 1));
      1:       w = 5'd31;
      2, 3:    w = 5'($urandom_range(2, 6));
      default: w = 5'($urandom_range(7, 30));
    endcase
    if (phase == 1) w = 5'd31;
    if (phase == 0) w = 5'd0;
    // short window so the long hold-off backs up into the input
    if (phase == 3) w = 5'd2;
    case ($urandom_range(0, 5))
      0:       c = 16'h8000;
      1:       c = 16'h7fff;
      2, 3:    c = 16'($urandom_range(0, 1536) - 768);
      4:       c = 16'($urandom);
      default: c = '0;
    endcase
    cfg_write(CFG_CUTOFF, c);
    cfg_write(CFG_DIST_MODE, {15'($urandom), 1'($urandom_range(0, 1))});
    cfg_write(CFG_WINDOW, {11'($urandom), w});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: score mode, cutoff zero, window 3; extremes and the cutoff itself
    send_val(0, 1'b0);
    send_val(-1, 1'b0);
    send_val(32767, 1'b0);
    send_val(32767, 1'b0);
    send_val(32767, 1'b0);
    send_val(32767, 1'b0);
    send_val(-32768, 1'b0);
    send_val(1, 1'b1);

    // Distance mode, window zero: every raw mark survives
    settle();
    cfg_write(CFG_SPARE_IDX, 16'hffff);
    cfg_write(CFG_DIST_MODE, 16'hffff);
    cfg_write(CFG_CUTOFF, 16'sd256);
    cfg_write(CFG_WINDOW, 16'hffe0);
    send_val(0, 1'b0);
    send_val(1, 1'b0);
    send_val(256, 1'b0);
    send_val(257, 1'b0);
    send_val(-5, 1'b0);
    send_val(100, 1'b1);

    // Window one, score mode, top cutoff
    settle();
    cfg_write(CFG_WINDOW, 16'hffe1);
    cfg_write(CFG_DIST_MODE, 16'hfffe);
    cfg_write(CFG_CUTOFF, 16'h7fff);
    send_val(32767, 1'b0);
    send_val(32767, 1'b0);
    send_val(32766, 1'b1);

    // Window lowered mid-sequence: one transaction releases the backlog
    settle();
    cfg_write(CFG_CUTOFF, 16'h8000);
    cfg_write(CFG_WINDOW, 16'd8);
    repeat (5) send_val(int'($urandom_range(0, 65535)) - 32768, 1'b0);
    settle();
    cfg_write(CFG_WINDOW, 16'd2);
    send_val(-32768, 1'b0);

    // Window raised mid-sequence: output waits for the lookahead
    settle();
    cfg_write(CFG_WINDOW, 16'd6);
    send_val(12, 1'b0);
    send_val(-7, 1'b0);
    send_val(5, 1'b1);

    // Random phases; sequences run across the setting changes
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      random_config(phase);
      tx_idle_en = (phase != 5);
      rx_idle_en = (phase != 5);
      if (phase == 3) begin
        @(posedge clk);
        hold_left = LONG_HOLD;
      end
      send_stream(PHASE_ITEMS);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_val(int'($urandom_range(0, 65535)) - 32768, 1'b1);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
